/* hdl/kvt_pkg.sv */
// ---------------------------------------------------------------------------
// kvt_pkg
// Shared types, character codes and helpers for the key/value tokenizer.
// ---------------------------------------------------------------------------
package kvt_pkg;

   // Default number of result entries held between the parser and the output.
   localparam int KVT_QUEUE_DEPTH = 4;

   // Characters with a special meaning in the text.
   localparam logic [7:0] CH_EQ = 8'h3D;
   localparam logic [7:0] CH_SQ = 8'h27;
   localparam logic [7:0] CH_DQ = 8'h22;

   // Parser phase, one-hot.
   typedef enum logic [6:0] {
      PH_SKIP_NAME = 7'b0000001,
      PH_NAME      = 7'b0000010,
      PH_SKIP_EQ   = 7'b0000100,
      PH_SKIP_VAL  = 7'b0001000,
      PH_QUOTED    = 7'b0010000,
      PH_PLAIN     = 7'b0100000,
      PH_IGNORE    = 7'b1000000
   } phase_type;

   // Kind of one result item.
   typedef enum logic [2:0] {
      KIND_NONE  = 3'd0,
      KIND_NAME  = 3'd1,
      KIND_VALUE = 3'd2,
      KIND_DONE  = 3'd3,
      KIND_DROP  = 3'd4
   } token_kind_type;

   // One result item as it travels to the output.
   typedef struct packed {
      token_kind_type kind;
      logic [7:0]     tbyte;
      logic           run_end;
      logic           text_end;
   } result_type;

   // Results produced by one text byte, pushed into the output queue.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   // Space, tab, line feed, vertical tab, form feed and return.
   function automatic logic is_space(input logic [7:0] c);
      return c inside {8'h20, [8'h09:8'h0D]};
   endfunction

   // Builds a result; the byte is carried only for name and value kinds.
   function automatic result_type make_result(input token_kind_type kind,
                                              input logic [7:0] c);
      result_type r;
      r.kind     = kind;
      r.tbyte    = (kind == KIND_NAME || kind == KIND_VALUE) ? c : 8'h00;
      r.run_end  = 1'b0;
      r.text_end = 1'b0;
      return r;
   endfunction

endpackage

/* hdl/key_value_pair_tokenizer.sv */
// ---------------------------------------------------------------------------
// key_value_pair_tokenizer
// Splits attribute text into name=value pairs, one byte per clock when not stalled.
// ---------------------------------------------------------------------------
// The block accepts one text byte per clock and tags every name and value
// byte, marks each complete pair done and each incomplete pair dropped, and
// flags the last result of every byte and of every text. A byte yields zero,
// one or two results; the output delivers one result per clock from a small
// queue while the receiver does not stall, so the input runs at one byte per
// clock as long as bytes average at most one result each and the output is
// not stalled; a byte with two results can stall the input once the queue
// has filled. A byte passes the input register, then the queue register,
// before its results reach the output.
module key_value_pair_tokenizer #(
   parameter int QueueDepth = kvt_pkg::KVT_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_token_kind,
   output logic [7:0] rsp_token_byte,
   output logic       rsp_run_end,
   output logic       rsp_text_end
);
   import kvt_pkg::*;

   push_type push;
   logic     room;

   // Parser with its input register.
   kvt_parse u_parse (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_text_byte  (req_text_byte),
      .req_final_byte (req_final_byte),
      .room           (room),
      .push           (push)
   );

   // Result queue driving the output channel.
   kvt_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .room           (room),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_token_kind (rsp_token_kind),
      .rsp_token_byte (rsp_token_byte),
      .rsp_run_end    (rsp_run_end),
      .rsp_text_end   (rsp_text_end)
   );

endmodule

/* hdl/kvt_parse.sv */
// ---------------------------------------------------------------------------
// kvt_parse
// Input register and pair parser. Takes one text byte per cycle while the output
// queue has room and turns it into zero, one or two result items for that queue.
// ---------------------------------------------------------------------------
module kvt_parse (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_text_byte,
   input  logic             req_final_byte,
   input  logic             room,
   output kvt_pkg::push_type push
);
   import kvt_pkg::*;

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           in_fin_ff;
   phase_type      phase_ff, phase_in;
   logic           sq_ff, sq_in;
   logic           first_ff, first_in;

   logic           fire;
   logic           accept;
   phase_type      ph_mid;
   logic           sq_mid;
   logic           ws;
   logic           main_put;
   token_kind_type main_kind;
   logic           end_put;
   token_kind_type end_kind;
   logic           quote_close;

   // The held byte is processed whenever the queue has room for two results.
   assign fire      = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign accept    = req_valid && !req_stall;
   assign ws        = is_space(in_byte_ff);
   assign quote_close = sq_ff ? (in_byte_ff == CH_SQ) : (in_byte_ff == CH_DQ);

   // Input register occupancy.
   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Main step: phase transition and the byte's own result.
   always_comb begin
      ph_mid    = phase_ff;
      sq_mid    = sq_ff;
      main_put  = 1'b0;
      main_kind = KIND_NONE;
      if (first_ff && in_byte_ff == 8'h00) begin
         ph_mid = PH_IGNORE;
      end else begin
         case (phase_ff)
            PH_SKIP_NAME: begin
               if (in_byte_ff == CH_EQ) begin
                  ph_mid = PH_SKIP_VAL;
               end else if (!ws) begin
                  main_put  = 1'b1;
                  main_kind = KIND_NAME;
                  ph_mid    = PH_NAME;
               end
            end
            PH_NAME: begin
               if (in_byte_ff == CH_EQ) begin
                  ph_mid = PH_SKIP_VAL;
               end else if (ws) begin
                  ph_mid = PH_SKIP_EQ;
               end else begin
                  main_put  = 1'b1;
                  main_kind = KIND_NAME;
               end
            end
            PH_SKIP_EQ: begin
               if (in_byte_ff == CH_EQ) begin
                  ph_mid = PH_SKIP_VAL;
               end else if (!ws) begin
                  main_put  = 1'b1;
                  main_kind = KIND_DROP;
                  ph_mid    = PH_IGNORE;
               end
            end
            PH_SKIP_VAL: begin
               if (in_byte_ff inside {CH_SQ, CH_DQ}) begin
                  sq_mid = (in_byte_ff == CH_SQ);
                  ph_mid = PH_QUOTED;
               end else if (!ws) begin
                  main_put  = 1'b1;
                  main_kind = KIND_VALUE;
                  ph_mid    = PH_PLAIN;
               end
            end
            PH_QUOTED: begin
               main_put = 1'b1;
               if (quote_close) begin
                  main_kind = KIND_DONE;
                  ph_mid    = PH_SKIP_NAME;
               end else begin
                  main_kind = KIND_VALUE;
               end
            end
            PH_PLAIN: begin
               main_put = 1'b1;
               if (ws) begin
                  main_kind = KIND_DONE;
                  ph_mid    = PH_SKIP_NAME;
               end else begin
                  main_kind = KIND_VALUE;
               end
            end
            default: begin
               ph_mid = PH_IGNORE;
            end
         endcase
      end
   end

   // End of text: an unfinished pair is closed as done or dropped.
   always_comb begin
      end_put  = 1'b0;
      end_kind = KIND_NONE;
      if (in_fin_ff) begin
         case (ph_mid)
            PH_NAME, PH_SKIP_EQ, PH_SKIP_VAL: begin
               end_put  = 1'b1;
               end_kind = KIND_DROP;
            end
            PH_QUOTED, PH_PLAIN: begin
               end_put  = 1'b1;
               end_kind = KIND_DONE;
            end
            default: begin
               end_put = 1'b0;
            end
         endcase
      end
   end

   // Pack the results into slots and mark the last one.
   always_comb begin
      push.first  = make_result(KIND_NONE, 8'h00);
      push.second = make_result(KIND_NONE, 8'h00);
      push.count  = 2'd0;
      if (fire) begin
         if (main_put && end_put) begin
            push.first           = make_result(main_kind, in_byte_ff);
            push.second          = make_result(end_kind, 8'h00);
            push.second.run_end  = 1'b1;
            push.second.text_end = 1'b1;
            push.count           = 2'd2;
         end else if (main_put) begin
            push.first          = make_result(main_kind, in_byte_ff);
            push.first.run_end  = 1'b1;
            push.first.text_end = in_fin_ff;
            push.count          = 2'd1;
         end else if (end_put || in_fin_ff) begin
            // A final byte with nothing else to say still shows the text end.
            push.first          = make_result(end_kind, 8'h00);
            push.first.run_end  = 1'b1;
            push.first.text_end = 1'b1;
            push.count          = 2'd1;
         end
      end
   end

   // Next parser state; the final byte returns everything to its start.
   always_comb begin
      phase_in = phase_ff;
      sq_in    = sq_ff;
      first_in = first_ff;
      if (fire) begin
         if (in_fin_ff) begin
            phase_in = PH_SKIP_NAME;
            sq_in    = 1'b0;
            first_in = 1'b1;
         end else begin
            phase_in = ph_mid;
            sq_in    = sq_mid;
            first_in = 1'b0;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PH_SKIP_NAME;
         sq_ff       <= 1'b0;
         first_ff    <= 1'b1;
      end else begin
         in_valid_ff <= in_valid_in;
         phase_ff    <= phase_in;
         sq_ff       <= sq_in;
         first_ff    <= first_in;
      end
   end

   // Input payload register.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_text_byte;
         in_fin_ff  <= req_final_byte;
      end
   end

   // A processed final byte leaves the parser at the start of a new text.
   a_fin_restart: assert property (@(posedge clock) disable iff (reset)
      fire && in_fin_ff |=> phase_ff == PH_SKIP_NAME && first_ff && !sq_ff)
      else $error("parser did not restart after the final byte");

   // Only a byte that is not final may produce no result at all.
   a_silent_not_final: assert property (@(posedge clock) disable iff (reset)
      fire && push.count == 2'd0 |-> !in_fin_ff)
      else $error("final byte produced no result");

   // Outside the text start, the ignore phase never emits a name or value byte in the first result slot.
   a_ignore_quiet: assert property (@(posedge clock) disable iff (reset)
      fire && phase_ff == PH_IGNORE && !first_ff |->
         push.first.kind != KIND_NAME && push.first.kind != KIND_VALUE)
      else $error("byte emitted while ignoring the rest of the text");

endmodule

/* hdl/kvt_queue.sv */
// ---------------------------------------------------------------------------
// kvt_queue
// Small result queue. Takes up to two results per cycle from the parser and
// hands one result per cycle to the output channel while it is not stalled.
// ---------------------------------------------------------------------------
module kvt_queue #(
   parameter int Depth = kvt_pkg::KVT_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  kvt_pkg::push_type push,
   output logic              room,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_token_kind,
   output logic [7:0]        rsp_token_byte,
   output logic              rsp_run_end,
   output logic              rsp_text_end
);
   import kvt_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   result_type         entry_ff [Depth];
   logic [PtrW-1:0]    head_ff, head_in;
   logic [PtrW-1:0]    tail_ff, tail_in;
   logic [PtrW-1:0]    tail_next;
   logic [CntW-1:0]    count_ff, count_in;
   logic               pop;
   result_type         head_entry;

   function automatic logic [PtrW-1:0] step_ptr(input logic [PtrW-1:0] p);
      return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
   endfunction

   // Room is judged on the current fill, leaving space for a two-result item.
   assign room      = count_ff <= CntW'(Depth - 2);
   assign rsp_valid = count_ff != '0;
   assign pop       = rsp_valid && !rsp_stall;
   assign tail_next = step_ptr(tail_ff);

   // Output fields come straight from the head entry register.
   assign head_entry     = entry_ff[head_ff];
   assign rsp_token_kind = head_entry.kind;
   assign rsp_token_byte = head_entry.tbyte;
   assign rsp_run_end    = head_entry.run_end;
   assign rsp_text_end   = head_entry.text_end;

   // Pointer and fill bookkeeping.
   always_comb begin
      head_in  = pop ? step_ptr(head_ff) : head_ff;
      tail_in  = tail_ff;
      if (push.count == 2'd1) begin
         tail_in = tail_next;
      end else if (push.count == 2'd2) begin
         tail_in = step_ptr(tail_next);
      end
      count_in = count_ff + CntW'(push.count) - CntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Entry storage: first result at the tail, second right behind it.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[tail_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[tail_next] <= push.second;
      end
   end

   // The fill never exceeds the storage.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("result queue overflow");

   // Results are only pushed while there is room for them.
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> room)
      else $error("push without room");

   // With nothing pushed and nothing popped, the fill holds.
   a_fill_holds: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd0 && !pop |=> $stable(count_ff))
      else $error("queue fill changed without traffic");

endmodule

/* tb/sv/testbench.sv */
// ---------------------------------------------------------------------------
// Key/value tokenizer testbench
// Feeds attribute texts byte by byte into the tokenizer and checks every
// token against a cycle-free model of the parser. The model follows each
// accepted byte, so checking holds under any amount of idling or stalling.
// ---------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import kvt_pkg::*;

   // One byte of text waiting to be sent.
   typedef struct packed {
      logic [7:0] text;
      logic       fin;
   } text_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_text_byte = 8'h00;
   logic       req_final_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_token_kind;
   logic [7:0] rsp_token_byte;
   logic       rsp_run_end;
   logic       rsp_text_end;

   text_item_type pending_bytes[$];
   result_type    expected_tokens[$];

   // Parser state as the model sees it.
   phase_type parse_phase = PH_SKIP_NAME;
   logic      quote_single = 1'b0;
   logic      at_text_start = 1'b1;

   // Idling controls; the stimulus sets them on the falling edge, the receiver counts the holds on the rising edge.
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_asked = 0;
   int hold_served = 0;
   int hold_left = 0;

   int failures = 0;
   int texts_queued = 0;
   int bytes_queued = 0;
   int tokens_checked = 0;
   int pairs_done = 0;
   int pairs_dropped = 0;

   key_value_pair_tokenizer i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_text_byte  (req_text_byte),
      .req_final_byte (req_final_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_token_kind (rsp_token_kind),
      .rsp_token_byte (rsp_token_byte),
      .rsp_run_end    (rsp_run_end),
      .rsp_text_end   (rsp_text_end)
   );

   // Clock with a 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Whitespace as the parser defines it.
   function automatic logic is_blank(input logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   // Builds one token; only name and value tokens carry their byte.
   function automatic result_type token(input token_kind_type kind, input logic [7:0] c);
      result_type t;
      t.kind     = kind;
      t.tbyte    = (kind == KIND_NAME || kind == KIND_VALUE) ? c : 8'h00;
      t.run_end  = 1'b0;
      t.text_end = 1'b0;
      return t;
   endfunction

   // Advances the parser model by one byte and queues the tokens it causes.
   task automatic predict_tokens(input logic [7:0] c, input logic fin);
      result_type found[$];
      logic       blank;
      blank = is_blank(c);
      if (at_text_start && c == 8'h00) begin
         parse_phase = PH_IGNORE;
      end else begin
         case (parse_phase)
            PH_SKIP_NAME: begin
               if (c == CH_EQ) begin
                  parse_phase = PH_SKIP_VAL;
               end else if (!blank) begin
                  found.push_back(token(KIND_NAME, c));
                  parse_phase = PH_NAME;
               end
            end
            PH_NAME: begin
               if (c == CH_EQ) begin
                  parse_phase = PH_SKIP_VAL;
               end else if (blank) begin
                  parse_phase = PH_SKIP_EQ;
               end else begin
                  found.push_back(token(KIND_NAME, c));
               end
            end
            PH_SKIP_EQ: begin
               if (c == CH_EQ) begin
                  parse_phase = PH_SKIP_VAL;
               end else if (!blank) begin
                  found.push_back(token(KIND_DROP, c));
                  parse_phase = PH_IGNORE;
               end
            end
            PH_SKIP_VAL: begin
               if (c == CH_SQ || c == CH_DQ) begin
                  quote_single = (c == CH_SQ);
                  parse_phase = PH_QUOTED;
               end else if (!blank) begin
                  found.push_back(token(KIND_VALUE, c));
                  parse_phase = PH_PLAIN;
               end
            end
            PH_QUOTED: begin
               if (c == (quote_single ? CH_SQ : CH_DQ)) begin
                  found.push_back(token(KIND_DONE, c));
                  parse_phase = PH_SKIP_NAME;
               end else begin
                  found.push_back(token(KIND_VALUE, c));
               end
            end
            PH_PLAIN: begin
               if (blank) begin
                  found.push_back(token(KIND_DONE, c));
                  parse_phase = PH_SKIP_NAME;
               end else begin
                  found.push_back(token(KIND_VALUE, c));
               end
            end
            default: parse_phase = PH_IGNORE;
         endcase
      end
      at_text_start = 1'b0;

      // The final byte closes whatever pair is still open.
      if (fin) begin
         case (parse_phase)
            PH_NAME, PH_SKIP_EQ, PH_SKIP_VAL: found.push_back(token(KIND_DROP, c));
            PH_QUOTED, PH_PLAIN: found.push_back(token(KIND_DONE, c));
            default: ;
         endcase
         if (found.size() == 0) found.push_back(token(KIND_NONE, c));
         found[found.size() - 1].text_end = 1'b1;
         parse_phase = PH_SKIP_NAME;
         quote_single = 1'b0;
         at_text_start = 1'b1;
      end
      if (found.size() > 0) found[found.size() - 1].run_end = 1'b1;
      foreach (found[i]) expected_tokens.push_back(found[i]);
   endtask

   // Draws a random byte; solid excludes whitespace, avoid values of -1 mean none.
   function automatic logic [7:0] random_char(input logic solid, input logic no_eq,
                                              input int avoid_a, input int avoid_b);
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(255));
      end while ((solid && is_blank(c)) || (no_eq && c == CH_EQ) ||
                 c == avoid_a || c == avoid_b);
      return c;
   endfunction

   // Picks one of the six whitespace bytes.
   function automatic logic [7:0] blank_char();
      logic [7:0] c;
      c = 8'($urandom_range(5));
      return (c == 8'd5) ? 8'h20 : 8'h09 + c;
   endfunction

   // Queues a whole text, flagging its last byte.
   task automatic queue_text(input logic [7:0] text[$]);
      text_item_type item;
      foreach (text[i]) begin
         item.text = text[i];
         item.fin  = (i == text.size() - 1);
         pending_bytes.push_back(item);
      end
      texts_queued++;
      bytes_queued += text.size();
   endtask

   // Builds one random text: mostly well-formed pairs, sometimes cut short,
   // plus missing equals signs, zero-led texts and raw noise.
   task automatic queue_random_text(output int counted);
      logic [7:0] text[$];
      logic [7:0] quote;
      int         pick;
      int         pairs;
      int         ignored;
      int         keep;
      ignored = 0;
      pick = $urandom_range(99);
      if (pick < 70) begin
         pairs = $urandom_range(3, 1);
         for (int p = 0; p < pairs; p++) begin
            repeat ($urandom_range(2)) text.push_back(blank_char());
            repeat ($urandom_range(4)) text.push_back(random_char(1'b1, 1'b1, -1, -1));
            repeat ($urandom_range(2)) text.push_back(blank_char());
            text.push_back(CH_EQ);
            repeat ($urandom_range(2)) text.push_back(blank_char());
            if ($urandom_range(1)) begin
               quote = $urandom_range(1) ? CH_SQ : CH_DQ;
               text.push_back(quote);
               repeat ($urandom_range(5)) text.push_back(random_char(1'b0, 1'b0, quote, quote));
               text.push_back(quote);
            end else begin
               text.push_back(random_char(1'b1, 1'b0, CH_SQ, CH_DQ));
               repeat ($urandom_range(4)) text.push_back(random_char(1'b1, 1'b0, -1, -1));
            end
            if (p < pairs - 1) repeat ($urandom_range(2, 1)) text.push_back(blank_char());
         end
         // Some texts end early, anywhere inside a pair.
         if ($urandom_range(99) < 15) begin
            keep = $urandom_range(text.size(), 1);
            text = text[0:keep - 1];
         end
      end else if (pick < 80) begin
         repeat ($urandom_range(3, 1)) text.push_back(random_char(1'b1, 1'b1, -1, -1));
         repeat ($urandom_range(2, 1)) text.push_back(blank_char());
         text.push_back(random_char(1'b1, 1'b1, -1, -1));
         ignored = $urandom_range(3);
         repeat (ignored) text.push_back(8'($urandom_range(255)));
      end else if (pick < 88) begin
         text.push_back(8'h00);
         ignored = $urandom_range(3);
         repeat (ignored) text.push_back(8'($urandom_range(255)));
      end else begin
         repeat ($urandom_range(8, 1)) text.push_back(8'($urandom_range(255)));
      end
      // A zero lead byte would silence a structured text.
      if (pick < 80 && text[0] == 8'h00) text[0] = 8'h61;
      queue_text(text);
      counted = text.size() - ignored;
   endtask

   // Waits until every byte is sent and every token has come back.
   task automatic drain_tokens();
      for (int k = 0; k < 20000; k++) begin
         if (pending_bytes.size() == 0 && !req_valid && expected_tokens.size() == 0) break;
         @(negedge clock);
      end
      repeat (6) @(negedge clock);
   endtask

   // Driver: updates the model on acceptance and offers the next byte.
   always @(posedge clock) begin
      text_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_tokens(req_text_byte, req_final_byte);
         if (!req_valid || !req_stall) begin
            if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               item = pending_bytes.pop_front();
               req_valid      <= 1'b1;
               req_text_byte  <= item.text;
               req_final_byte <= item.fin;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall, with a long hold-off whenever one is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_asked) begin
         rsp_stall   <= 1'b1;
         hold_left   <= 80;
         hold_served <= hold_served + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Monitor: compares each accepted token with the oldest expectation.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         tokens_checked++;
         if (rsp_token_kind == KIND_DONE) pairs_done++;
         if (rsp_token_kind == KIND_DROP) pairs_dropped++;
         if (expected_tokens.size() == 0) begin
            $error("unexpected token: kind %0d byte %02h", rsp_token_kind, rsp_token_byte);
            failures++;
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_token_kind !== want.kind) begin
               $error("token_kind: expected %0d, got %0d", want.kind, rsp_token_kind);
               failures++;
            end
            if (rsp_token_byte !== want.tbyte) begin
               $error("token_byte: expected %02h, got %02h", want.tbyte, rsp_token_byte);
               failures++;
            end
            if (rsp_run_end !== want.run_end) begin
               $error("run_end: expected %0d, got %0d", want.run_end, rsp_run_end);
               failures++;
            end
            if (rsp_text_end !== want.text_end) begin
               $error("text_end: expected %0d, got %0d", want.text_end, rsp_text_end);
               failures++;
            end
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      logic [7:0] text[$];
      int         counted;
      int         phase_items;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed texts, no idling.
      text = '{8'h00};
      queue_text(text);
      text = '{CH_EQ, CH_DQ, 8'hFF, CH_DQ, 8'h20};
      queue_text(text);
      text = '{8'h6B, 8'h0B, CH_EQ, 8'h0C, CH_SQ, 8'h00};
      queue_text(text);
      text = '{8'h6E, 8'h0A, 8'h78, 8'h79};
      queue_text(text);
      text = '{8'h70};
      queue_text(text);
      text = '{8'h71, 8'h0D};
      queue_text(text);
      text = '{CH_EQ, 8'h09};
      queue_text(text);
      text = '{CH_EQ, CH_SQ};
      queue_text(text);
      text = '{CH_EQ, 8'h76, 8'h09, 8'h77, CH_EQ, 8'h75};
      queue_text(text);
      drain_tokens();

      // Random texts under four idling patterns; the sender waits for
      // every token between patterns.
      for (int mode = 0; mode < 4; mode++) begin
         send_idle_pct = (mode == 1) ? 53 : (mode == 3) ? 33 : 0;
         stall_pct     = (mode == 2) ? 53 : (mode == 3) ? 33 : 0;
         // The first pattern opens with a long output hold while bytes keep coming.
         if (mode == 0) hold_asked++;
         phase_items = 0;
         while (phase_items < 163) begin
            queue_random_text(counted);
            phase_items += counted;
         end
         drain_tokens();
      end

      if (expected_tokens.size() != 0) begin
         $error("%0d expected tokens never arrived", expected_tokens.size());
         failures++;
      end
      $display("Sent %0d texts, %0d bytes, under four idling patterns and a long hold.",
               texts_queued, bytes_queued);
      $display("Checked %0d tokens: %0d pairs done, %0d dropped.",
               tokens_checked, pairs_done, pairs_dropped);
      if (failures == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule
